// File: src/nsc_pkg.sv
// nsc_pkg: shared constants, types and a helper function of the nmea sentence checker
// used by nsc_line_tracker and nmea_sentence_checker_top; depends on nothing
`default_nettype none

package nsc_pkg;

  localparam int LINE_BYTES = 128;
  localparam int STAR_LIMIT = 75;

  localparam int CNT_W = $clog2(LINE_BYTES);
  localparam int POS_W = 11;
  localparam int LEN_W = 7;
  localparam int KIND_W = 2;

  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(LINE_BYTES - 1);
  localparam logic [POS_W-1:0] STAR_POS = POS_W'(STAR_LIMIT);

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_ZERO    = 8'h00;

  localparam int KIND_CNT = 3;
  localparam int KIND_LEN = 6;

  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GGA   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GLL   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RMC   = 2'd3;

  localparam logic [7:0] KIND_PAT [KIND_CNT][KIND_LEN] = '{
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41},   // $GPGGA
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h4C, 8'h4C},   // $GPGLL
    '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43}    // $GPRMC
  };

  typedef enum logic [4:0] {
    PH_START = 5'b00001,
    PH_SUM   = 5'b00010,
    PH_HEX1  = 5'b00100,
    PH_HEX2  = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [7:0]        check;
    logic [LEN_W-1:0]  length;
  } result_t;

  // uppercase ascii hex digit of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h37 + {4'd0, nib};
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: src/nsc_line_tracker.sv
// nsc_line_tracker: per-line state (count, running xor, phase, hex bytes, kind match)
// and the end-of-line verdict; depends on nsc_pkg
`default_nettype none

module nsc_line_tracker import nsc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output logic            line_end_o,
  output result_t         res_o
);

  logic [CNT_W-1:0]    count_q, count_d;
  logic [7:0]          xor_q, xor_d;
  phase_e              phase_q, phase_d;
  logic [7:0]          hex1_q, hex1_d;
  logic [7:0]          hex2_q, hex2_d;
  logic [KIND_CNT-1:0] match_q, match_d;
  logic                ended_q, ended_d;
  logic                bad_q, bad_d;

  logic [POS_W-1:0] pos_wide;
  logic             checksum_ok;
  logic [2:0]       pat_idx;

  assign line_end_o = (byte_i == CH_NEWLINE) || (count_q >= LAST_POS);
  assign pos_wide   = POS_W'(count_q);
  assign pat_idx    = 3'(count_q);

  assign checksum_ok = !bad_q && (phase_q == PH_DONE)
                    && (hex1_q == hex_char(xor_q[7:4]))
                    && (hex2_q == hex_char(xor_q[3:0]));

  always_comb begin
    res_o.valid  = checksum_ok;
    res_o.kind   = KIND_OTHER;
    res_o.check  = xor_q;
    res_o.length = LEN_W'(count_q);
    if (checksum_ok && (count_q >= CNT_W'(KIND_LEN))) begin
      if (match_q[0]) begin
        res_o.kind = KIND_GGA;
      end else if (match_q[1]) begin
        res_o.kind = KIND_GLL;
      end else if (match_q[2]) begin
        res_o.kind = KIND_RMC;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    xor_d   = xor_q;
    phase_d = phase_q;
    hex1_d  = hex1_q;
    hex2_d  = hex2_q;
    match_d = match_q;
    ended_d = ended_q;
    bad_d   = bad_q;
    if (step_i) begin
      if (line_end_o) begin
        count_d = '0;
        xor_d   = '0;
        phase_d = PH_START;
        hex1_d  = '0;
        hex2_d  = '0;
        match_d = '1;
        ended_d = 1'b0;
        bad_d   = 1'b0;
      end else begin
        if (count_q < CNT_W'(KIND_LEN)) begin
          for (int k = 0; k < KIND_CNT; k++) begin
            if (byte_i != KIND_PAT[k][pat_idx]) begin
              match_d[k] = 1'b0;
            end
          end
        end
        // validation stops after a zero byte or a failure
        if (!ended_q && !bad_q) begin
          case (phase_q)
            PH_START: begin
              if (byte_i == CH_DOLLAR) begin
                phase_d = PH_SUM;
              end else begin
                bad_d = 1'b1;
              end
            end
            PH_SUM: begin
              if ((pos_wide >= STAR_POS) || (byte_i == CH_ZERO)) begin
                bad_d = 1'b1;
              end else if (byte_i == CH_STAR) begin
                phase_d = PH_HEX1;
              end else begin
                xor_d = xor_q ^ byte_i;
              end
            end
            PH_HEX1: begin
              hex1_d  = byte_i;
              phase_d = PH_HEX2;
            end
            PH_HEX2: begin
              hex2_d  = byte_i;
              phase_d = PH_DONE;
            end
            default: begin
            end
          endcase
        end
        if (byte_i == CH_ZERO) begin
          ended_d = 1'b1;
        end
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      xor_q   <= '0;
      phase_q <= PH_START;
      hex1_q  <= '0;
      hex2_q  <= '0;
      match_q <= '1;
      ended_q <= 1'b0;
      bad_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      xor_q   <= xor_d;
      phase_q <= phase_d;
      hex1_q  <= hex1_d;
      hex2_q  <= hex2_d;
      match_q <= match_d;
      ended_q <= ended_d;
      bad_q   <= bad_d;
    end
  end

endmodule

`default_nettype wire

// File: src/nmea_sentence_checker_top.sv
// nmea_sentence_checker_top: input byte register, line tracker and result register
// depends on nsc_pkg and nsc_line_tracker
//
//   channel  handshake              payload
//   in       in_valid_i/in_ready_o  rx_byte_i
//   out      out_valid_o/out_ready_i sentence_valid_o, sentence_kind_o,
//                                   computed_check_o, line_length_o
//
// one byte per cycle unless a line-ending byte waits on a full result register; a byte
// sits in the input register and then updates the line state; a line end loads the
// result register from the line state as its byte leaves the input register
// reset clears the line state and both registers' valid flags
// only a line-ending byte waits on a full result register; other bytes flow on
`default_nettype none

module nmea_sentence_checker_top import nsc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        rx_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   sentence_valid_o,
  output logic [KIND_W-1:0]      sentence_kind_o,
  output logic [7:0]             computed_check_o,
  output logic [LEN_W-1:0]       line_length_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       line_end;
  logic       advance;
  result_t    res;
  logic       out_valid_q;
  result_t    out_q;

  assign advance    = in_valid_q && (!line_end || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  nsc_line_tracker u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (in_byte_q),
    .line_end_o (line_end),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && line_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && line_end) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sentence_valid_o = out_q.valid;
  assign sentence_kind_o  = out_q.kind;
  assign computed_check_o = out_q.check;
  assign line_length_o    = out_q.length;

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// tb_top: self-checking bench for nmea_sentence_checker_top, byte stream in, one result per line
// depends on nsc_pkg and the checker rtl; directed edge-case lines, then random sentences
`timescale 1ns / 1ps

module tb_top;
  import nsc_pkg::*;

  typedef struct {
    logic [7:0] b;
    bit         has_exp;
    result_t    exp;
  } tx_item_t;

  // one directed line: text, filler run, optional good checksum, optional zero byte,
  // ended by newline or by running past the line store
  typedef struct {
    string      txt;
    logic [7:0] fillc;
    int         fill;
    bit         fix;
    int         zpos;
    bit         over;
    bit         has_exp;
    result_t    exp;
  } dir_row_t;

  localparam int N_DIR = 20;
  localparam logic [8*16-1:0] HEX_ASCII = "0123456789ABCDEF";

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready_o;
  logic [7:0]        rx_byte = 8'h00;
  logic              out_valid_o;
  logic              out_ready = 1'b0;
  logic              sentence_valid_o;
  logic [KIND_W-1:0] sentence_kind_o;
  logic [7:0]        computed_check_o;
  logic [LEN_W-1:0]  line_length_o;

  tx_item_t tx_bytes [$];
  result_t  pending_sentences [$];
  tx_item_t cur;
  dir_row_t dir_tab [N_DIR];

  // line state of the predictor
  int         ln_cnt = 0;
  logic [7:0] ln_xor = 8'h00;
  phase_e     ln_ph = PH_START;
  logic [7:0] ln_h1 = 8'h00;
  logic [7:0] ln_h2 = 8'h00;
  logic [2:0] ln_match = 3'b111;
  bit         ln_zero = 1'b0;
  bit         ln_bad = 1'b0;

  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int n_err = 0;
  int n_bytes = 0;
  int n_lines = 0;
  int n_good = 0;
  int n_kind [4] = '{0, 0, 0, 0};

  nmea_sentence_checker_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .sentence_valid_o (sentence_valid_o),
    .sentence_kind_o  (sentence_kind_o),
    .computed_check_o (computed_check_o),
    .line_length_o    (line_length_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    return HEX_ASCII[8*(15-nib) +: 8];
  endfunction

  task automatic report_err(input string msg);
    n_err++;
    if (n_err <= 50) $display("tb_top: mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic clear_line();
    ln_cnt = 0;
    ln_xor = 8'h00;
    ln_ph = PH_START;
    ln_h1 = 8'h00;
    ln_h2 = 8'h00;
    ln_match = 3'b111;
    ln_zero = 1'b0;
    ln_bad = 1'b0;
  endtask

  // advance the line state by one byte; done is set when the byte closes a line
  task automatic nmea_track_byte(input logic [7:0] b, output bit done, output result_t r);
    bit ok;
    int k;
    done = 1'b0;
    r = '0;
    if (b != CH_NEWLINE && ln_cnt < LINE_BYTES - 1) begin
      if (ln_cnt < KIND_LEN) begin
        for (k = 0; k < KIND_CNT; k++) begin
          if (b != KIND_PAT[k][ln_cnt]) ln_match[k] = 1'b0;
        end
      end
      if (!ln_zero && !ln_bad) begin
        case (ln_ph)
          PH_START: begin
            if (b == CH_DOLLAR) ln_ph = PH_SUM;
            else ln_bad = 1'b1;
          end
          PH_SUM: begin
            if (ln_cnt >= STAR_LIMIT || b == CH_ZERO) ln_bad = 1'b1;
            else if (b == CH_STAR) ln_ph = PH_HEX1;
            else ln_xor ^= b;
          end
          PH_HEX1: begin
            ln_h1 = b;
            ln_ph = PH_HEX2;
          end
          PH_HEX2: begin
            ln_h2 = b;
            ln_ph = PH_DONE;
          end
          default: ;
        endcase
      end
      if (b == CH_ZERO) ln_zero = 1'b1;
      ln_cnt++;
    end else begin
      ok = !ln_bad && ln_ph == PH_DONE && ln_h1 == hex_ascii(ln_xor[7:4])
           && ln_h2 == hex_ascii(ln_xor[3:0]);
      r.valid = ok;
      r.kind = KIND_OTHER;
      if (ok && ln_cnt >= KIND_LEN) begin
        if (ln_match[0]) r.kind = KIND_GGA;
        else if (ln_match[1]) r.kind = KIND_GLL;
        else if (ln_match[2]) r.kind = KIND_RMC;
      end
      r.check = ln_xor;
      r.length = LEN_W'(ln_cnt);
      done = 1'b1;
      clear_line();
    end
  endtask

  // sender: offers queued bytes, predicts on every accepted one
  always @(posedge clk_i) begin
    bit done;
    result_t r;
    bit take;
    take = in_valid && in_ready_o;
    if (take) begin
      n_bytes++;
      nmea_track_byte(cur.b, done, r);
      if (done) pending_sentences.push_back(cur.has_exp ? cur.exp : r);
    end
    if (!in_valid || take) begin
      if (rst_ni && tx_bytes.size() > 0 && (in_calm || $urandom_range(99) >= 10)) begin
        cur = tx_bytes.pop_front();
        rx_byte <= cur.b;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: checks each result against the oldest expected sentence
  always @(posedge clk_i) begin
    result_t want;
    if (out_valid_o && out_ready) begin
      if (pending_sentences.size() == 0) begin
        report_err("result with no sentence expected");
      end else begin
        want = pending_sentences.pop_front();
        n_lines++;
        if (want.valid) n_good++;
        n_kind[want.kind]++;
        if (sentence_valid_o != want.valid)
          report_err($sformatf("valid got %0d want %0d", sentence_valid_o, want.valid));
        if (sentence_kind_o != want.kind)
          report_err($sformatf("kind got %0d want %0d", sentence_kind_o, want.kind));
        if (computed_check_o != want.check)
          report_err($sformatf("check got %02h want %02h", computed_check_o, want.check));
        if (line_length_o != want.length)
          report_err($sformatf("length got %0d want %0d", line_length_o, want.length));
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_ni && (out_calm || $urandom_range(99) >= 10);
    end
  end

  task automatic push_line(input logic [7:0] ln [$], input bit has_exp, input result_t exp);
    tx_item_t it;
    int i;
    for (i = 0; i < ln.size(); i++) begin
      it.b = ln[i];
      it.has_exp = has_exp && (i == ln.size() - 1);
      it.exp = exp;
      tx_bytes.push_back(it);
    end
  endtask

  task automatic queue_row(input dir_row_t row);
    logic [7:0] ln [$];
    logic [7:0] sum;
    int i;
    ln = {};
    for (i = 0; i < row.txt.len(); i++) ln.push_back(row.txt[i]);
    repeat (row.fill) ln.push_back(row.fillc);
    if (row.fix) begin
      sum = 8'h00;
      for (i = 1; i < ln.size(); i++) sum ^= ln[i];
      ln.push_back(CH_STAR);
      ln.push_back(hex_ascii(sum[7:4]));
      ln.push_back(hex_ascii(sum[3:0]));
    end
    if (row.zpos >= 0) ln.insert(row.zpos, CH_ZERO);
    // a line past the store ends on the byte that gets dropped
    ln.push_back(row.over ? 8'h5A : CH_NEWLINE);
    push_line(ln, row.has_exp, row.exp);
  endtask

  // mostly well-formed sentences with random content, some broken, some noise
  task automatic queue_random(input int budget);
    logic [7:0] ln [$];
    logic [7:0] sum;
    logic [7:0] c;
    int pushed;
    int pick;
    int len;
    int i;
    pushed = 0;
    while (pushed < budget) begin
      ln = {};
      pick = $urandom_range(99);
      if (pick < 70) begin
        ln.push_back(CH_DOLLAR);
        pick = $urandom_range(3);
        for (i = 1; i < KIND_LEN; i++)
          ln.push_back(pick < KIND_CNT ? KIND_PAT[pick][i] : 8'($urandom_range(8'h41, 8'h5A)));
        if ($urandom_range(99) < 15)
          ln[$urandom_range(1, KIND_LEN - 1)] = 8'($urandom_range(8'h20, 8'h7E));
        // a few long bodies push the star past its limit
        len = ($urandom_range(99) < 6) ? $urandom_range(60, 80) : $urandom_range(0, 20);
        repeat (len) begin
          c = 8'($urandom_range(8'h20, 8'h7E));
          ln.push_back(c == CH_STAR ? 8'h2C : c);
        end
        sum = 8'h00;
        for (i = 1; i < ln.size(); i++) sum ^= ln[i];
        ln.push_back(CH_STAR);
        ln.push_back(hex_ascii(sum[7:4]));
        ln.push_back(hex_ascii(sum[3:0]));
        if ($urandom_range(99) < 25) begin
          case ($urandom_range(4))
            0: ln[ln.size() - 1] ^= 8'(1 << $urandom_range(7));
            1: ln[ln.size() - 2] |= 8'h20;
            2: void'(ln.pop_back());
            3: ln.insert($urandom_range(ln.size() - 1), CH_ZERO);
            default: repeat ($urandom_range(1, 4)) ln.push_back(8'($urandom_range(255)));
          endcase
        end
        ln.push_back(CH_NEWLINE);
      end else if (pick < 97) begin
        if ($urandom_range(1)) ln.push_back(CH_DOLLAR);
        repeat ($urandom_range(0, 12)) ln.push_back(8'($urandom_range(255)));
        ln.push_back(CH_NEWLINE);
      end else begin
        if ($urandom_range(1)) ln.push_back(CH_DOLLAR);
        while (ln.size() < LINE_BYTES) ln.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end
      push_line(ln, 1'b0, '0);
      pushed += ln.size();
    end
  endtask

  task automatic wait_drained();
    while (tx_bytes.size() > 0 || in_valid || pending_sentences.size() > 0)
      @(negedge clk_i);
  endtask

  initial begin
    int i;
    dir_tab = '{
      '{"",        8'h78,   0, 0, -1, 0, 1, {1'b0, KIND_OTHER, 8'h00, 7'd0}},
      '{"Q",       8'h78,   0, 0, -1, 0, 1, {1'b0, KIND_OTHER, 8'h00, 7'd1}},
      '{"$",       8'h78,   0, 0, -1, 0, 1, {1'b0, KIND_OTHER, 8'h00, 7'd1}},
      '{"$",       8'h78,   0, 1, -1, 0, 1, {1'b1, KIND_OTHER, 8'h00, 7'd4}},
      '{"$GPGGA,123", 8'h78, 0, 1, -1, 0, 0, '0},
      '{"$GPGLL,4",   8'h78, 0, 1, -1, 0, 0, '0},
      '{"$GPRMC,a,b", 8'h78, 0, 1, -1, 0, 0, '0},
      '{"$GPXYZ",  8'h78,   0, 1, -1, 0, 0, '0},
      '{"$GPGGA*00", 8'h78, 0, 0, -1, 0, 0, '0},
      '{"$J*4a",   8'h78,   0, 0, -1, 0, 0, '0},
      '{"$J*4A",   8'h78,   0, 0, -1, 0, 0, '0},
      // zero byte inside the summed part, at a hex digit, and after a good checksum
      '{"$GPGGA,1", 8'h78,  0, 1,  3, 0, 0, '0},
      '{"$J*4",    8'h78,   0, 0,  4, 0, 0, '0},
      '{"$J*4A",   8'h7A,   2, 0,  5, 0, 0, '0},
      '{"$J*4",    8'h78,   0, 0, -1, 0, 0, '0},
      // star just below and at its position limit
      '{"$",       8'h78,  73, 1, -1, 0, 0, '0},
      '{"$",       8'h78,  74, 1, -1, 0, 0, '0},
      '{"$",       8'hFF,   3, 1, -1, 0, 1, {1'b1, KIND_OTHER, 8'hFF, 7'd7}},
      '{" $J*4A",  8'h78,   0, 0, -1, 0, 1, {1'b0, KIND_OTHER, 8'h00, 7'd6}},
      '{"$",       8'h78, 126, 0, -1, 1, 1, {1'b0, KIND_OTHER, 8'h00, 7'd127}}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (i = 0; i < N_DIR; i++) queue_row(dir_tab[i]);
    queue_row(dir_tab[10]);
    wait_drained();

    queue_random(450);
    wait_drained();

    in_calm = 1'b1;
    out_calm = 1'b1;
    queue_random(300);
    wait_drained();
    out_calm = 1'b0;

    // receiver holds off while bytes keep coming, so line ends back up
    hold_req++;
    queue_random(300);
    wait_drained();
    in_calm = 1'b0;

    queue_random(300);
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("tb_top: %0d bytes, %0d lines checked, %0d with good checksum",
             n_bytes, n_lines, n_good);
    $display("tb_top: kinds other/gga/gll/rmc %0d/%0d/%0d/%0d, incl. stalls and overflow",
             n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
    if (n_err == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: timeout");
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// File: sim.f
src/nsc_pkg.sv
src/nsc_line_tracker.sv
src/nmea_sentence_checker_top.sv
bench/tb_top.sv
